>>> sv/rpei_pkg.sv
// Shared types and constants for the ray / polygon-edge intersection unit.
package rpei_pkg;

  // Widths of the vertex coordinates, their differences and the determinants
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int DET_W   = 2 * DIFF_W + 1;
  localparam int REM_W   = DET_W + 1;

  // Hit fraction format: Q1.FRACTION_BITS, one spare bit to encode 2.0
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 2;
  localparam int QUOT_W        = FRACTION_BITS + 1;

  localparam logic [FRAC_W-1:0] NO_HIT = {2'b10, {FRACTION_BITS{1'b0}}};

  // Configuration register map
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_END_X   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAY_END_Y   = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [DET_W-1:0]   det_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      polygon_first;
    logic                      polygon_last;
    logic                      scene_last;
  } in_item_t;

  typedef struct packed {
    logic [FRAC_W-1:0] hit_fraction;
    logic              hit_found;
  } out_item_t;

endpackage

>>> sv/rpei_det_unit.sv
// Bit-serial 2x2 determinant: ux*vy - vx*uy, one multiplier bit per cycle, MSB first.
module rpei_det_unit import rpei_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  diff_t ux,
  input  diff_t uy,
  input  diff_t vx,
  input  diff_t vy,
  output det_t  det,
  output logic  done
);

  localparam int CNT_W = $clog2(DIFF_W);

  diff_t              ux_r;
  diff_t              vx_r;
  logic [DIFF_W-1:0]  uy_sh_r;
  logic [DIFF_W-1:0]  vy_sh_r;
  det_t               acc_r;
  det_t               acc_nxt;
  det_t               term;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  // Form the partial term for the current bit of vy and uy
  always_comb begin
    term = (vy_sh_r[DIFF_W-1] ? DET_W'(ux_r) : '0)
         - (uy_sh_r[DIFF_W-1] ? DET_W'(vx_r) : '0);
    // The top bit of a two's complement multiplier carries negative weight
    if (cnt_r == '0) begin
      acc_nxt = '0 - term;
    end else begin
      acc_nxt = (acc_r <<< 1) + term;
    end
  end

  // Advance the shift registers and the accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIFF_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ux_r    <= ux;
      vx_r    <= vx;
      uy_sh_r <= uy;
      vy_sh_r <= vy;
      acc_r   <= '0;
    end else if (busy_r) begin
      uy_sh_r <= uy_sh_r << 1;
      vy_sh_r <= vy_sh_r << 1;
      acc_r   <= acc_nxt;
    end
  end

  assign det  = acc_r;
  assign done = done_r;

endmodule

>>> sv/rpei_divider.sv
// Restoring divider: floor(num * 2^FRACTION_BITS / den) for 0 <= num <= den, one bit per cycle.
module rpei_divider import rpei_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  det_t              num,
  input  det_t              den,
  output logic [QUOT_W-1:0] quot,
  output logic              done
);

  localparam int CNT_W = $clog2(QUOT_W);

  logic [REM_W-1:0]  rem_r;
  logic [REM_W-1:0]  rem_nxt;
  logic [REM_W-1:0]  den_r;
  logic [QUOT_W-1:0] quot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  // Compare, subtract and shift one quotient bit
  always_comb begin
    ge      = rem_r >= den_r;
    rem_nxt = (ge ? rem_r - den_r : rem_r) << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= {1'b0, den};
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

  assign quot = quot_r;
  assign done = done_r;

  // The partial remainder stays below twice the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < (den_r << 1))
    else $error("divider remainder out of range");

endmodule

>>> sv/ray_polygon_edge_intersection_unit.sv
// Top level: ray / polygon-edge nearest-hit unit with serial determinant and divide units.
//
//   port group   direction  handshake        payload
//   in_*         input      in_valid/ready   in_item_t (vertex, polygon/scene marks)
//   out_*        output     out_valid/ready  out_item_t (hit_fraction, hit_found)
//   cfg_*        input      cfg_we only      cfg_addr, cfg_wdata (ray endpoints)
//
// Each edge runs through dispatch, the determinant units (33 multiplier bits, set by the
// 33-bit coordinate differences), the normalize and range checks, and the divider
// (17 quotient bits).
// A vertex forms no edge, an open or closing edge, or both; the nearest hit is emitted at scene end.
// An edge with zero determinant or out of range skips the divide.
// Reset (synchronous, rst_n low) clears the ray, vertex history and nearest hit.
// A pending result waits in the output register; a new vertex is taken meanwhile.
module ray_polygon_edge_intersection_unit import rpei_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_DET      = 3'd2;
  localparam logic [2:0] S_NORM     = 3'd3;
  localparam logic [2:0] S_RANGE    = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  logic [2:0]        state_r;
  logic [2:0]        state_nxt;

  coord_t            rs_x_r, rs_y_r, re_x_r, re_y_r;
  coord_t            first_x_r, first_y_r, prev_x_r, prev_y_r;
  coord_t            cur_x_r, cur_y_r;
  logic              edge_open_r, edge_close_r, scene_last_r;
  logic [FRAC_W-1:0] nearest_r;
  det_t              d_r, n0_r, n1_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_xfer;
  logic              det_start;
  logic              div_start;
  logic              hit;
  coord_t            p0_x, p0_y, p1_x, p1_y;
  diff_t             a_x, a_y, b_x, b_y, c_x, c_y;
  det_t              det_d, det_n0, det_n1;
  logic              d_done, n0_done, n1_done;
  logic [QUOT_W-1:0] div_quot;
  logic              div_done;
  logic              out_free;

  assign in_xfer  = in_valid && in_ready;
  assign in_ready = state_r == S_IDLE;
  assign out_free = !out_valid_r || out_ready;

  // Pick the edge endpoints: open edge first, closing edge second
  always_comb begin
    if (edge_open_r) begin
      p0_x = prev_x_r;
      p0_y = prev_y_r;
      p1_x = cur_x_r;
      p1_y = cur_y_r;
    end else begin
      p0_x = cur_x_r;
      p0_y = cur_y_r;
      p1_x = first_x_r;
      p1_y = first_y_r;
    end
    a_x = DIFF_W'(rs_x_r) - DIFF_W'(re_x_r);
    a_y = DIFF_W'(rs_y_r) - DIFF_W'(re_y_r);
    b_x = DIFF_W'(rs_x_r) - DIFF_W'(p0_x);
    b_y = DIFF_W'(rs_y_r) - DIFF_W'(p0_y);
    c_x = DIFF_W'(p1_x) - DIFF_W'(p0_x);
    c_y = DIFF_W'(p1_y) - DIFF_W'(p0_y);
  end

  // Range check on the sign-normalized numerators
  assign hit = !n0_r[DET_W-1] && !n1_r[DET_W-1] && (n0_r <= d_r) && (n1_r <= d_r);

  // Sequence the edges of one vertex
  always_comb begin
    state_nxt = state_r;
    det_start = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (edge_open_r || edge_close_r) begin
          det_start = 1'b1;
          state_nxt = S_DET;
        end else if (scene_last_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DET: begin
        if (d_done) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        state_nxt = (det_d == '0) ? S_DISPATCH : S_RANGE;
      end
      S_RANGE: begin
        if (hit) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, vertex history and nearest hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rs_x_r       <= '0;
      rs_y_r       <= '0;
      re_x_r       <= '0;
      re_y_r       <= '0;
      first_x_r    <= '0;
      first_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      edge_open_r  <= 1'b0;
      edge_close_r <= 1'b0;
      scene_last_r <= 1'b0;
      nearest_r    <= NO_HIT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Take configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_RAY_START_X: rs_x_r <= cfg_wdata;
          REG_RAY_START_Y: rs_y_r <= cfg_wdata;
          REG_RAY_END_X:   re_x_r <= cfg_wdata;
          REG_RAY_END_Y:   re_y_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // Latch a vertex and the edges it forms
      if (in_xfer) begin
        edge_open_r  <= !in_data.polygon_first;
        edge_close_r <= in_data.polygon_last;
        scene_last_r <= in_data.scene_last;
        if (in_data.polygon_first) begin
          first_x_r <= in_data.vertex_x;
          first_y_r <= in_data.vertex_y;
        end
      end

      // Retire the edge being started; update previous vertex when done
      if (state_r == S_DISPATCH) begin
        if (edge_open_r) begin
          edge_open_r <= 1'b0;
        end else if (edge_close_r) begin
          edge_close_r <= 1'b0;
        end else begin
          prev_x_r <= cur_x_r;
          prev_y_r <= cur_y_r;
        end
      end

      // Keep the smallest fraction
      if (state_r == S_DIV && div_done && (FRAC_W'(div_quot) < nearest_r)) begin
        nearest_r <= FRAC_W'(div_quot);
      end

      // Drain and load the output register
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
        nearest_r   <= NO_HIT;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_x_r <= in_data.vertex_x;
      cur_y_r <= in_data.vertex_y;
    end
    if (state_r == S_NORM) begin
      if (det_d[DET_W-1]) begin
        d_r  <= '0 - det_d;
        n0_r <= '0 - det_n0;
        n1_r <= '0 - det_n1;
      end else begin
        d_r  <= det_d;
        n0_r <= det_n0;
        n1_r <= det_n1;
      end
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r.hit_fraction <= nearest_r;
      out_data_r.hit_found    <= nearest_r < NO_HIT;
    end
  end

  rpei_det_unit u_det_d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (det_start),
    .ux    (a_x),
    .uy    (a_y),
    .vx    (c_x),
    .vy    (c_y),
    .det   (det_d),
    .done  (d_done)
  );

  rpei_det_unit u_det_n0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (det_start),
    .ux    (b_x),
    .uy    (b_y),
    .vx    (c_x),
    .vy    (c_y),
    .det   (det_n0),
    .done  (n0_done)
  );

  rpei_det_unit u_det_n1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (det_start),
    .ux    (a_x),
    .uy    (a_y),
    .vx    (b_x),
    .vy    (b_y),
    .det   (det_n1),
    .done  (n1_done)
  );

  rpei_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (n0_r),
    .den   (d_r),
    .quot  (div_quot),
    .done  (div_done)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The three determinant units run in lockstep
  a_det_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (d_done == n0_done) && (d_done == n1_done))
    else $error("determinant units out of step");

  // A divide only runs on a positive divisor with numerator in range
  a_div_operands: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (!d_r[DET_W-1] && (d_r != '0) && (n0_r <= d_r)))
    else $error("divider operands out of range");

  // The nearest fraction never exceeds the no-hit code
  a_nearest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nearest_r <= NO_HIT)
    else $error("nearest fraction above no-hit code");

  // The hit flag agrees with the fraction it travels with
  a_out_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.hit_found == (out_data_r.hit_fraction < NO_HIT)))
    else $error("hit flag disagrees with fraction");

endmodule
